/* hw/rtl/vlrs_pkg.sv */
package vlrs_pkg;

	// Action codes
	localparam logic [1:0] ACT_PUSH  = 2'd0;
	localparam logic [1:0] ACT_EMPTY = 2'd1;
	localparam logic [1:0] ACT_POP   = 2'd2;
	localparam logic [1:0] ACT_DROP  = 2'd3;

	// Status codes
	localparam logic [1:0] STAT_OK     = 2'd0;
	localparam logic [1:0] STAT_NOROOM = 2'd1;
	localparam logic [1:0] STAT_EMPTY  = 2'd2;

	localparam int ADDR_W = 16;
	localparam logic [12:0] SIZE_RESET = 13'd4096;

	typedef struct packed {
		logic [1:0]  action;
		logic [7:0]  data_in;
		logic        last_in;
		logic [15:0] receive_limit;
	} in_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [7:0]  data_out;
		logic        byte_valid;
		logic        last_out;
		logic [15:0] bytes_copied;
		logic [15:0] top_length;
		logic [12:0] free_bytes;
		logic [11:0] object_count;
	} out_t;

	typedef struct packed {
		logic              en;
		logic              we;
		logic [ADDR_W-1:0] addr;
		logic [7:0]        wdata;
	} ram_req_t;

endpackage

/* hw/rtl/vlrs_ram.sv */
module vlrs_ram #(
	parameter int DEPTH = 4096
) (
	input  logic               clk,
	input  vlrs_pkg::ram_req_t req,
	output logic [7:0]         rdata
);

	localparam int AW = $clog2(DEPTH);

	logic [7:0] mem [DEPTH];

	// single port, read data registered, valid in the cycle after the request
	always_ff @(posedge clk) begin
		if (req.en) begin
			if (req.we) begin
				mem[req.addr[AW-1:0]] <= req.wdata;
			end else begin
				rdata <= mem[req.addr[AW-1:0]];
			end
		end
	end

endmodule

/* hw/rtl/variable_length_record_stack_top.sv */
// The result strobe follows the S_DONE state, which ends every word's memory sequence.
// Push byte with commit: up to 3 memory writes (data, two trailer bytes).
// Pop that removes its object: up to a byte read plus two trailer reads of the new top.
// busy drops with the result strobe, so the next word may start in that cycle.
// One single-port byte memory, one access a cycle; the result side never stalls.
// Reset clears the stack pointer, counts and pop state; memory is not cleared.
module variable_length_record_stack_top #(
	parameter int MEM_DEPTH = 4096
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	output logic           busy,
	input  vlrs_pkg::in_t  item,
	input  logic           cfg_we,
	input  logic [12:0]    cfg_wdata,
	output logic           done,
	output vlrs_pkg::out_t result
);

	// Sequencer states: each memory access gets its own cycle.
	typedef enum logic [9:0] {
		S_IDLE    = 10'b0000000001,
		S_WR_DATA = 10'b0000000010,
		S_WR_TLO  = 10'b0000000100,
		S_WR_THI  = 10'b0000001000,
		S_RD_BYTE = 10'b0000010000,
		S_RD_DATA = 10'b0000100000,
		S_LD_LO   = 10'b0001000000,
		S_LD_HI   = 10'b0010000000,
		S_LD_CAP  = 10'b0100000000,
		S_DONE    = 10'b1000000000
	} state_t;

	localparam logic [16:0] DEPTH_W = 17'(MEM_DEPTH);

	state_t state_q, state_d;

	// Architectural state
	logic [12:0] size_q;
	logic [12:0] top_q;
	logic [11:0] cnt_q;
	logic [15:0] pend_q;
	logic        pop_act_q;
	logic [12:0] cur_q;
	logic [12:0] stop_q;
	logic [12:0] ntop_q;
	logic [15:0] tlen_q;     // cached trailer of the top object, 0 below two bytes

	// Planned memory work for the current word
	logic tr_q, ld_q;

	// Per-word payload
	logic [12:0] da_q, ta_q, ra_q;
	logic [7:0]  d_q, lo_byte_q, dout_q;
	logic [15:0] tv_q, copied_q;
	logic [1:0]  stat_q;
	logic        bv_q, lo_q;
	logic        done_q;
	vlrs_pkg::out_t res_q;

	vlrs_pkg::ram_req_t ram_req;
	logic [7:0]         ram_rdata;

	logic accept;

	// Decode of the incoming word
	logic [12:0] sz;
	logic [16:0] addr_push;
	logic        wr_ok;
	logic [15:0] pend_inc;
	logic        commit_ok;
	logic        empty_ok;
	logic        top_ok;
	logic [12:0] ntop_calc;
	logic [15:0] lim_min;
	logic [12:0] stop_calc;
	logic [12:0] cur_e, stop_e, ntop_e;
	logic        byte_rd;
	logic [12:0] cur_n;
	logic        fin;
	logic        pop_go;
	logic [12:0] ld_top;
	logic        wd_c, tr_c, rd_c, ld_c;
	logic [12:0] fr_raw;

	assign accept = start && (state_q == S_IDLE);
	assign busy   = (state_q != S_IDLE);
	assign done   = done_q;
	assign result = res_q;

	always_comb begin
		sz        = (17'(size_q) < DEPTH_W) ? size_q : 13'(MEM_DEPTH);
		addr_push = 17'(top_q) + 17'(pend_q);
		wr_ok     = addr_push < 17'(sz);
		pend_inc  = (pend_q == 16'hFFFF) ? pend_q : pend_q + 16'd1;
		commit_ok = (18'(top_q) + 18'd2 + 18'(pend_inc)) < 18'(sz);
		empty_ok  = (14'(top_q) + 14'd2) < 14'(sz);
		top_ok    = (top_q >= 13'd2) && (17'(top_q) >= 17'(tlen_q) + 17'd2);
		ntop_calc = 13'(17'(top_q) - 17'(tlen_q) - 17'd2);
		lim_min   = (tlen_q < item.receive_limit) ? tlen_q : item.receive_limit;
		stop_calc = ntop_calc + 13'(lim_min);
		cur_e     = pop_act_q ? cur_q  : ntop_calc;
		stop_e    = pop_act_q ? stop_q : stop_calc;
		ntop_e    = pop_act_q ? ntop_q : ntop_calc;
		byte_rd   = cur_e < stop_e;
		cur_n     = byte_rd ? cur_e + 13'd1 : cur_e;
		fin       = cur_n >= stop_e;
		pop_go    = pop_act_q || top_ok;
		ld_top    = (item.action == vlrs_pkg::ACT_DROP) ? ntop_calc : ntop_e;

		wd_c = (item.action == vlrs_pkg::ACT_PUSH) && wr_ok;
		tr_c = ((item.action == vlrs_pkg::ACT_PUSH) && item.last_in && commit_ok)
			|| ((item.action == vlrs_pkg::ACT_EMPTY) && empty_ok);
		rd_c = (item.action == vlrs_pkg::ACT_POP) && pop_go && byte_rd;
		ld_c = (((item.action == vlrs_pkg::ACT_POP) && pop_go && fin)
			|| ((item.action == vlrs_pkg::ACT_DROP) && top_ok))
			&& (ld_top >= 13'd2);

		fr_raw = (size_q > top_q) ? size_q - top_q : 13'd0;
	end

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (start) begin
					if (wd_c)      state_d = S_WR_DATA;
					else if (tr_c) state_d = S_WR_TLO;
					else if (rd_c) state_d = S_RD_BYTE;
					else if (ld_c) state_d = S_LD_LO;
					else           state_d = S_DONE;
				end
			end
			S_WR_DATA: state_d = tr_q ? S_WR_TLO : S_DONE;
			S_WR_TLO:  state_d = S_WR_THI;
			S_WR_THI:  state_d = S_DONE;
			S_RD_BYTE: state_d = S_RD_DATA;
			S_RD_DATA: state_d = ld_q ? S_LD_LO : S_DONE;
			S_LD_LO:   state_d = S_LD_HI;
			S_LD_HI:   state_d = S_LD_CAP;
			S_LD_CAP:  state_d = S_DONE;
			S_DONE:    state_d = S_IDLE;
			default:   state_d = S_IDLE;
		endcase
	end

	// Memory port request
	always_comb begin
		ram_req = '0;
		case (state_q)
			S_WR_DATA: begin
				ram_req.en    = 1'b1;
				ram_req.we    = 1'b1;
				ram_req.addr  = vlrs_pkg::ADDR_W'(da_q);
				ram_req.wdata = d_q;
			end
			S_WR_TLO: begin
				ram_req.en    = 1'b1;
				ram_req.we    = 1'b1;
				ram_req.addr  = vlrs_pkg::ADDR_W'(ta_q);
				ram_req.wdata = tv_q[7:0];
			end
			S_WR_THI: begin
				ram_req.en    = 1'b1;
				ram_req.we    = 1'b1;
				ram_req.addr  = vlrs_pkg::ADDR_W'(ta_q + 13'd1);
				ram_req.wdata = tv_q[15:8];
			end
			S_RD_BYTE: begin
				ram_req.en   = 1'b1;
				ram_req.addr = vlrs_pkg::ADDR_W'(ra_q);
			end
			S_LD_LO: begin
				ram_req.en   = 1'b1;
				ram_req.addr = vlrs_pkg::ADDR_W'(top_q - 13'd2);
			end
			S_LD_HI: begin
				ram_req.en   = 1'b1;
				ram_req.addr = vlrs_pkg::ADDR_W'(top_q - 13'd1);
			end
			default: ram_req = '0;
		endcase
	end

	vlrs_ram #(
		.DEPTH (MEM_DEPTH)
	) u_ram (
		.clk   (clk),
		.req   (ram_req),
		.rdata (ram_rdata)
	);

	// Control and stack state. All pointer/count updates land when the word is
	// taken; the memory sequence that follows only moves bytes and reloads the trailer cache.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			size_q    <= vlrs_pkg::SIZE_RESET;
			top_q     <= '0;
			cnt_q     <= '0;
			pend_q    <= '0;
			pop_act_q <= 1'b0;
			cur_q     <= '0;
			stop_q    <= '0;
			ntop_q    <= '0;
			tlen_q    <= '0;
			tr_q      <= 1'b0;
			ld_q      <= 1'b0;
			done_q    <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= (state_q == S_DONE);
			if (cfg_we) begin
				size_q <= cfg_wdata;
			end
			if (state_q == S_LD_CAP) begin
				tlen_q <= {ram_rdata, lo_byte_q};
			end
			if (accept) begin
				tr_q <= tr_c;
				ld_q <= ld_c;
				if (item.action != vlrs_pkg::ACT_POP) begin
					pop_act_q <= 1'b0;
				end
				if (item.action != vlrs_pkg::ACT_PUSH) begin
					pend_q <= '0;
				end
				case (item.action)
					vlrs_pkg::ACT_PUSH: begin
						if (item.last_in) begin
							pend_q <= '0;
							if (commit_ok) begin
								top_q  <= 13'(18'(top_q) + 18'(pend_inc) + 18'd2);
								tlen_q <= pend_inc;
								if (cnt_q != 12'hFFF) cnt_q <= cnt_q + 12'd1;
							end
						end else begin
							pend_q <= pend_inc;
						end
					end
					vlrs_pkg::ACT_EMPTY: begin
						if (empty_ok) begin
							top_q  <= top_q + 13'd2;
							tlen_q <= '0;
							if (cnt_q != 12'hFFF) cnt_q <= cnt_q + 12'd1;
						end
					end
					vlrs_pkg::ACT_POP: begin
						if (pop_go) begin
							if (fin) begin
								top_q     <= ntop_e;
								pop_act_q <= 1'b0;
								if (cnt_q != 12'd0) cnt_q <= cnt_q - 12'd1;
								if (ntop_e < 13'd2) tlen_q <= '0;
							end else begin
								pop_act_q <= 1'b1;
							end
							cur_q  <= cur_n;
							stop_q <= stop_e;
							ntop_q <= ntop_e;
						end
					end
					vlrs_pkg::ACT_DROP: begin
						if (top_ok) begin
							top_q <= ntop_calc;
							if (cnt_q != 12'd0) cnt_q <= cnt_q - 12'd1;
							if (ntop_calc < 13'd2) tlen_q <= '0;
						end
					end
					default: ;
				endcase
			end
		end
	end

	// Word payload, addresses and the result register
	always_ff @(posedge clk) begin
		if (accept) begin
			da_q     <= addr_push[12:0];
			d_q      <= item.data_in;
			ra_q     <= cur_e;
			dout_q   <= '0;
			bv_q     <= rd_c;
			lo_q     <= 1'b0;
			copied_q <= '0;
			stat_q   <= vlrs_pkg::STAT_OK;
			case (item.action)
				vlrs_pkg::ACT_PUSH: begin
					ta_q <= 13'(17'(top_q) + 17'(pend_inc));
					tv_q <= pend_inc;
					if (item.last_in && !commit_ok) stat_q <= vlrs_pkg::STAT_NOROOM;
				end
				vlrs_pkg::ACT_EMPTY: begin
					ta_q <= top_q;
					tv_q <= '0;
					if (!empty_ok) stat_q <= vlrs_pkg::STAT_NOROOM;
				end
				vlrs_pkg::ACT_POP: begin
					if (pop_go) begin
						copied_q <= 16'(cur_n - ntop_e);
						lo_q     <= fin;
					end else begin
						stat_q <= vlrs_pkg::STAT_EMPTY;
					end
				end
				vlrs_pkg::ACT_DROP: begin
					if (!top_ok) stat_q <= vlrs_pkg::STAT_EMPTY;
				end
				default: ;
			endcase
		end
		if (state_q == S_RD_DATA) begin
			dout_q <= ram_rdata;
		end
		if (state_q == S_LD_HI) begin
			lo_byte_q <= ram_rdata;
		end
		if (state_q == S_DONE) begin
			res_q.status       <= stat_q;
			res_q.data_out     <= dout_q;
			res_q.byte_valid   <= bv_q;
			res_q.last_out     <= lo_q;
			res_q.bytes_copied <= copied_q;
			res_q.top_length   <= (top_q < 13'd2) ? 16'd0 : tlen_q;
			res_q.free_bytes   <= (fr_raw > 13'd2) ? fr_raw - 13'd2 : 13'd0;
			res_q.object_count <= cnt_q;
		end
	end

	// Checks
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> state_q == S_IDLE)
		else $error("result strobe outside idle");

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> busy)
		else $error("word taken without going busy");

	a_pop_open: assert property (@(posedge clk) disable iff (!arst_n)
		pop_act_q |-> cur_q < stop_q)
		else $error("open pop with nothing left to return");

	a_low_top_len: assert property (@(posedge clk) disable iff (!arst_n)
		(top_q < 13'd2) |-> tlen_q == 16'd0)
		else $error("trailer cache nonzero below two bytes");

endmodule

/* dv/variable_length_record_stack_top_tb.sv */
module variable_length_record_stack_top_tb;

	localparam int MEM_BYTES   = 4096;
	localparam int CYCLE_LIMIT = 4_000_000;
	localparam int LONG_PUSH   = 40;	// longer than the room left under a small size

	// clock, reset, DUT ports; every input known from time zero
	logic           clk       = 1'b0;
	logic           arst_n    = 1'b0;
	logic           start     = 1'b0;
	logic           busy;
	vlrs_pkg::in_t  item      = '0;
	logic           cfg_we    = 1'b0;
	logic [12:0]    cfg_wdata = '0;
	logic           done;
	vlrs_pkg::out_t result;

	// words waiting to go out, and replies predicted for words already taken
	vlrs_pkg::in_t  pending_words[$];
	vlrs_pkg::out_t predicted_results[$];

	int   sender_idle_pct = 0;
	bit   word_taken      = 1'b0;
	int   mismatches      = 0;
	int   cycle_count     = 0;

	// shadow of the stack: memory, size register, pointers, push and pop state
	bit [7:0]    shadow_mem[MEM_BYTES];
	int unsigned shadow_size    = vlrs_pkg::SIZE_RESET;
	int unsigned shadow_top     = 0;
	int unsigned shadow_objects = 0;
	int unsigned push_count     = 0;
	bit          popping        = 1'b0;
	int unsigned pop_cursor     = 0;
	int unsigned pop_end        = 0;
	int unsigned pop_base       = 0;

	// lengths of objects queued by the stimulus, used to size pop bursts
	int pushed_lengths[$];

	variable_length_record_stack_top #(
		.MEM_DEPTH(MEM_BYTES)
	) i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.item      (item),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.done      (done),
		.result    (result)
	);

	always #10 clk = ~clk;

	// ---------------------------------------------------------------
	// Stack predictor
	// ---------------------------------------------------------------

	// memory beyond the array reads zero
	function automatic int unsigned mem_byte(int unsigned addr);
		return (addr < MEM_BYTES) ? shadow_mem[addr] : 0;
	endfunction

	// little-endian length trailer just below top; 0 on an empty stack
	function automatic int unsigned trailer_len();
		if (shadow_top < 2)
			return 0;
		return (mem_byte(shadow_top - 1) << 8) | mem_byte(shadow_top - 2);
	endfunction

	function automatic bit top_valid();
		return shadow_top >= 2 && shadow_top >= trailer_len() + 2;
	endfunction

	// bytes already sit above top; write the trailer and bump the count
	function automatic void commit_object(int unsigned len);
		shadow_top += len;
		if (shadow_top < MEM_BYTES)
			shadow_mem[shadow_top] = 8'(len & 'h00FF);
		if (shadow_top + 1 < MEM_BYTES)
			shadow_mem[shadow_top + 1] = 8'((len >> 8) & 'h00FF);
		shadow_top += 2;
		if (shadow_objects < 'hFFF)
			shadow_objects++;
	endfunction

	function automatic void remove_object(int unsigned new_top);
		shadow_top = new_top;
		if (shadow_objects > 0)
			shadow_objects--;
	endfunction

	// one word in, one reply out; updates the shadow state
	function automatic vlrs_pkg::out_t apply_word_to_stack(vlrs_pkg::in_t w);
		vlrs_pkg::out_t r;
		int unsigned    eff;
		int unsigned    addr;
		int unsigned    len;
		int unsigned    room;
		r = '0;
		eff = (shadow_size < MEM_BYTES) ? shadow_size : MEM_BYTES;
		// anything but pop abandons a pop; anything but push drops a partial push
		if (w.action != vlrs_pkg::ACT_POP)
			popping = 1'b0;
		if (w.action != vlrs_pkg::ACT_PUSH)
			push_count = 0;
		case (w.action)
			vlrs_pkg::ACT_PUSH: begin
				addr = shadow_top + push_count;
				if (addr < eff)
					shadow_mem[addr] = w.data_in;
				if (push_count < 'hFFFF)
					push_count++;
				if (w.last_in) begin
					len = push_count;
					push_count = 0;
					if (shadow_top + 2 + len < eff)
						commit_object(len);
					else
						r.status = vlrs_pkg::STAT_NOROOM;
				end
			end
			vlrs_pkg::ACT_EMPTY: begin
				if (shadow_top + 2 < eff)
					commit_object(0);
				else
					r.status = vlrs_pkg::STAT_NOROOM;
			end
			vlrs_pkg::ACT_POP: begin
				if (!popping) begin
					if (top_valid()) begin
						len = trailer_len();
						pop_base = shadow_top - 2 - len;
						pop_cursor = pop_base;
						pop_end = pop_base + ((len < w.receive_limit) ? len : w.receive_limit);
						popping = 1'b1;
					end else begin
						r.status = vlrs_pkg::STAT_EMPTY;
					end
				end
				if (popping) begin
					if (pop_cursor < pop_end) begin
						r.data_out = 8'(mem_byte(pop_cursor));
						r.byte_valid = 1'b1;
						pop_cursor++;
					end
					r.bytes_copied = 16'(pop_cursor - pop_base);
					if (pop_cursor >= pop_end) begin
						remove_object(pop_base);
						r.last_out = 1'b1;
						popping = 1'b0;
					end
				end
			end
			default: begin
				if (top_valid())
					remove_object(shadow_top - (trailer_len() + 2));
				else
					r.status = vlrs_pkg::STAT_EMPTY;
			end
		endcase
		// free space is taken from the register, not the clipped size
		room = (shadow_size > shadow_top) ? shadow_size - shadow_top : 0;
		room = (room > 2) ? room - 2 : 0;
		r.top_length = 16'(trailer_len());
		r.free_bytes = 13'(room);
		r.object_count = 12'(shadow_objects);
		return r;
	endfunction

	// ---------------------------------------------------------------
	// Checking
	// ---------------------------------------------------------------

	task automatic report_mismatch(string msg);
		mismatches++;
		$display("[%0t] mismatch: %s", $time, msg);
	endtask

	task automatic check_field(string name, logic [15:0] got, logic [15:0] want);
		if (got !== want)
			report_mismatch($sformatf("%s got 0x%0h want 0x%0h", name, got, want));
	endtask

	// ---------------------------------------------------------------
	// Driver: new word at the falling edge once the last one was taken
	// ---------------------------------------------------------------
	always @(negedge clk) begin
		if (arst_n && (!start || word_taken)) begin
			if (pending_words.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
				start <= 1'b1;
				item  <= pending_words.pop_front();
			end else begin
				start <= 1'b0;
			end
		end
	end

	// ---------------------------------------------------------------
	// Monitor: sample at the rising edge; check a strobed reply, then
	// predict for a word taken at this same edge
	// ---------------------------------------------------------------
	always @(posedge clk) begin : monitor
		vlrs_pkg::out_t want;
		word_taken = arst_n && start && !busy;
		if (arst_n && done) begin
			if (predicted_results.size() == 0) begin
				report_mismatch("reply strobed with no word outstanding");
			end else begin
				want = predicted_results.pop_front();
				check_field("status",       result.status,       want.status);
				check_field("data_out",     result.data_out,     want.data_out);
				check_field("byte_valid",   result.byte_valid,   want.byte_valid);
				check_field("last_out",     result.last_out,     want.last_out);
				check_field("bytes_copied", result.bytes_copied, want.bytes_copied);
				check_field("top_length",   result.top_length,   want.top_length);
				check_field("free_bytes",   result.free_bytes,   want.free_bytes);
				check_field("object_count", result.object_count, want.object_count);
			end
		end
		if (word_taken)
			predicted_results.push_back(apply_word_to_stack(item));
	end

	// hard stop in case the DUT hangs
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("*** FAILED ***");
			$finish;
		end
	end

	// ---------------------------------------------------------------
	// Stimulus helpers
	// ---------------------------------------------------------------

	task automatic queue_word(logic [1:0] act, logic [7:0] data, bit last, logic [15:0] lim);
		vlrs_pkg::in_t w;
		w.action = act;
		w.data_in = data;
		w.last_in = last;
		w.receive_limit = lim;
		pending_words.push_back(w);
	endtask

	// whole object as push words; a zero length goes out as an empty push
	task automatic queue_object(int len, bit finish_it);
		if (len == 0) begin
			queue_word(vlrs_pkg::ACT_EMPTY, 8'($urandom), 1'($urandom), 16'($urandom));
		end else begin
			for (int i = 0; i < len; i++)
				queue_word(vlrs_pkg::ACT_PUSH, 8'($urandom), finish_it && (i == len - 1),
					16'($urandom));
		end
	endtask

	// block idle: nothing left to send, nothing outstanding, then a latency pad
	task automatic settle();
		int waited;
		waited = 0;
		while (pending_words.size() != 0 || start)
			@(posedge clk);
		while (predicted_results.size() != 0 && waited < 1000) begin
			@(posedge clk);
			waited++;
		end
		if (predicted_results.size() != 0) begin
			report_mismatch($sformatf("%0d replies never arrived", predicted_results.size()));
			predicted_results.delete();
		end
		repeat (8) @(posedge clk);
	endtask

	// only called while idle; shadow follows at once since no word is in flight
	task automatic write_size(logic [12:0] value);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= value;
		shadow_size = value;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	// mostly whole objects and pop bursts that drain them, some broken
	// sequences and raw noise words
	task automatic queue_random(int count);
		int          made;
		int          pick;
		int          len;
		int          burst;
		logic [15:0] lim;
		logic [31:0] raw;
		made = 0;
		while (made < count) begin
			pick = $urandom_range(99);
			if (pick < 45) begin
				len = ($urandom_range(9) == 0) ? $urandom_range(40, 200) : $urandom_range(0, 12);
				// one in ten objects is cut off before its last byte
				queue_object(len, $urandom_range(9) != 0);
				pushed_lengths.push_back(len);
				made += (len == 0) ? 1 : len;
			end else if (pick < 80) begin
				case ($urandom_range(9))
					0, 1, 2: lim = 16'($urandom_range(0, 3));
					3, 4, 5, 6: lim = 16'($urandom_range(0, 20));
					7, 8: lim = 16'hFFFF;
					default: lim = 16'($urandom);
				endcase
				if (pushed_lengths.size() != 0 && $urandom_range(4) != 0) begin
					len = pushed_lengths.pop_back();
					burst = (len < lim) ? len : lim;
					if (burst == 0)
						burst = 1;
				end else begin
					burst = $urandom_range(1, 4);	// may stop a pop partway
				end
				for (int i = 0; i < burst; i++)
					queue_word(vlrs_pkg::ACT_POP, 8'($urandom), 1'($urandom), lim);
				made += burst;
			end else if (pick < 90) begin
				queue_word(vlrs_pkg::ACT_DROP, 8'($urandom), 1'($urandom), 16'($urandom));
				if (pushed_lengths.size() != 0)
					void'(pushed_lengths.pop_back());
				made++;
			end else begin
				raw = $urandom;
				pending_words.push_back(vlrs_pkg::in_t'(raw[26:0]));
				made++;
			end
		end
	endtask

	// ---------------------------------------------------------------
	// Test sequence
	// ---------------------------------------------------------------
	initial begin : sequencer
		int sizes[4];
		int idles[4];
		sizes = '{4096, 64, 300, 2048};
		idles = '{0, 57, 0, 14};

		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// directed, size at its reset value of 4096
		queue_word(vlrs_pkg::ACT_POP,  8'h00, 1'b0, 16'hFFFF);	// pop from empty stack
		queue_word(vlrs_pkg::ACT_DROP, 8'hFF, 1'b1, 16'h0000);	// drop from empty stack
		queue_word(vlrs_pkg::ACT_EMPTY, 8'h00, 1'b0, 16'h0000);
		queue_word(vlrs_pkg::ACT_POP,  8'h00, 1'b0, 16'd5);	// zero-length object
		queue_word(vlrs_pkg::ACT_PUSH, 8'h00, 1'b0, 16'h0000);
		queue_word(vlrs_pkg::ACT_PUSH, 8'hFF, 1'b0, 16'hFFFF);
		queue_word(vlrs_pkg::ACT_PUSH, 8'hA5, 1'b1, 16'h0000);
		queue_word(vlrs_pkg::ACT_PUSH, 8'h5A, 1'b1, 16'h0000);
		queue_word(vlrs_pkg::ACT_POP,  8'h00, 1'b0, 16'h0000);	// zero limit removes it
		repeat (3)
			queue_word(vlrs_pkg::ACT_POP, 8'h00, 1'b0, 16'hFFFF);
		queue_word(vlrs_pkg::ACT_PUSH, 8'h11, 1'b0, 16'h0000);
		queue_word(vlrs_pkg::ACT_PUSH, 8'h22, 1'b0, 16'h0000);
		queue_word(vlrs_pkg::ACT_PUSH, 8'h33, 1'b1, 16'h0000);
		repeat (2)
			queue_word(vlrs_pkg::ACT_POP, 8'h00, 1'b0, 16'd2);	// limit below length
		queue_word(vlrs_pkg::ACT_PUSH, 8'h3C, 1'b0, 16'h0000);
		queue_word(vlrs_pkg::ACT_PUSH, 8'hC3, 1'b1, 16'h0000);
		queue_word(vlrs_pkg::ACT_POP,  8'h00, 1'b0, 16'hFFFF);	// one byte, then...
		queue_word(vlrs_pkg::ACT_EMPTY, 8'h00, 1'b0, 16'h0000);	// ...pop abandoned
		queue_word(vlrs_pkg::ACT_DROP, 8'h00, 1'b0, 16'h0000);
		queue_word(vlrs_pkg::ACT_DROP, 8'h00, 1'b0, 16'h0000);
		queue_word(vlrs_pkg::ACT_PUSH, 8'h77, 1'b0, 16'h0000);	// partial push...
		queue_word(vlrs_pkg::ACT_POP,  8'h00, 1'b0, 16'hFFFF);	// ...discarded
		settle();

		// stack some objects, then shrink the size to zero, below top
		repeat (3)
			queue_object(6, 1'b1);
		settle();
		write_size(13'd0);
		queue_word(vlrs_pkg::ACT_EMPTY, 8'h00, 1'b0, 16'h0000);
		queue_word(vlrs_pkg::ACT_PUSH, 8'h81, 1'b1, 16'h0000);
		queue_word(vlrs_pkg::ACT_POP,  8'h00, 1'b0, 16'hFFFF);
		settle();

		// size just below top: nothing commits, drop still works
		write_size(13'd13);
		queue_word(vlrs_pkg::ACT_EMPTY, 8'h00, 1'b0, 16'h0000);
		queue_object(2, 1'b1);
		queue_word(vlrs_pkg::ACT_DROP, 8'h00, 1'b0, 16'h0000);
		settle();

		// size above the memory, then a small size that a long push runs past;
		// bytes beyond the buffer are not written and the object is rejected
		write_size(13'h1FFF);
		queue_object(4, 1'b1);
		queue_word(vlrs_pkg::ACT_DROP, 8'h00, 1'b0, 16'h0000);
		settle();
		write_size(13'd24);
		queue_object(LONG_PUSH, 1'b1);
		queue_word(vlrs_pkg::ACT_DROP, 8'h00, 1'b0, 16'h0000);
		settle();

		// random phases across sizes and sender idling
		for (int p = 0; p < 4; p++) begin
			write_size(13'(sizes[p]));
			sender_idle_pct = idles[p];
			pushed_lengths.delete();
			queue_random(110);
			settle();
		end

		if (mismatches == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule
